// ===== sv/rtrg_pkg.sv =====
// ----------------------------------------------------------------------------
// rtrg_pkg
// Shared constants and types for the rigid transform / range gate block.
// ----------------------------------------------------------------------------
package rtrg_pkg;

    // Generic defaults for the top level parameters
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_FRAC_DEF   = 14;

    // Fixed field widths of the packed row registers
    localparam int ROW_W     = 64;
    localparam int COEF_W    = 16;
    localparam int T_W       = 16;
    localparam int RANGE_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Magnitude limit for the range gate: |x'|, |y'| must stay below 2^ABS_W
    localparam int ABS_W     = 16;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0      = 2'd0,
        CFG_ROW1      = 2'd1,
        CFG_ROW2      = 2'd2,
        CFG_MAX_RANGE = 2'd3
    } cfg_idx_t;

    // Reset values: identity rotation, zero translation
    localparam logic [ROW_W-1:0]   ROW0_RESET      = 64'h4000_0000_0000_0000;
    localparam logic [ROW_W-1:0]   ROW1_RESET      = 64'h0000_4000_0000_0000;
    localparam logic [ROW_W-1:0]   ROW2_RESET      = 64'h0000_0000_4000_0000;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'd6400;

endpackage

// ===== sv/rigid_transform_range_gate_top.sv =====
// ----------------------------------------------------------------------------
// rigid_transform_range_gate_top
// Applies [R | t] to position and R to velocity of each detection, rounds,
// saturates and flags detections inside a horizontal range.
// ----------------------------------------------------------------------------
// Pipeline: five register stages, the first loaded at the accepting edge;
// m_valid is the valid of the last stage.
// Throughput: one word per cycle while m_ready is high; the five register
// stages each hold a word, empty stages are filled while the output stalls.
// Reset: aresetn (sync, active low) clears all stage valids and loads the
// identity transform and a max_range of 6400.
module rigid_transform_range_gate_top #(
    parameter int COORD_WIDTH    = rtrg_pkg::COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = rtrg_pkg::COEF_FRAC_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [rtrg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtrg_pkg::ROW_W-1:0]           cfg_wdata,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_pos_x,
    input  logic signed [COORD_WIDTH-1:0]        s_pos_y,
    input  logic signed [COORD_WIDTH-1:0]        s_pos_z,
    input  logic signed [COORD_WIDTH-1:0]        s_vel_x,
    input  logic signed [COORD_WIDTH-1:0]        s_vel_y,
    input  logic signed [COORD_WIDTH-1:0]        s_vel_z,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [COORD_WIDTH-1:0]        m_out_pos_x,
    output logic signed [COORD_WIDTH-1:0]        m_out_pos_y,
    output logic signed [COORD_WIDTH-1:0]        m_out_pos_z,
    output logic signed [COORD_WIDTH-1:0]        m_out_vel_x,
    output logic signed [COORD_WIDTH-1:0]        m_out_vel_y,
    output logic signed [COORD_WIDTH-1:0]        m_out_vel_z,
    output logic                                 m_keep,
    output logic                                 m_saturated
);

    localparam int CW     = COORD_WIDTH;
    localparam int F      = COEF_FRAC_BITS;
    localparam int COEF_W = rtrg_pkg::COEF_W;
    localparam int T_W    = rtrg_pkg::T_W;
    localparam int ROW_W  = rtrg_pkg::ROW_W;
    localparam int ABS_W  = rtrg_pkg::ABS_W;
    localparam int RNG_W  = rtrg_pkg::RANGE_W;
    localparam int PROD_W = COEF_W + CW;
    localparam int TSH_W  = T_W + F;
    localparam int ACC_W  = ((PROD_W > TSH_W) ? PROD_W : TSH_W) + 2;
    localparam int RND_W  = ACC_W - F;
    localparam int EXT_W  = (RND_W > CW) ? RND_W : CW;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int MSQ_W  = 2 * RNG_W;
    localparam int CMP_W  = ((SQ_W > MSQ_W) ? SQ_W : MSQ_W) + 1;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg [3];
    logic [RNG_W-1:0] max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]    <= rtrg_pkg::ROW0_RESET;
            row_reg[1]    <= rtrg_pkg::ROW1_RESET;
            row_reg[2]    <= rtrg_pkg::ROW2_RESET;
            max_range_reg <= rtrg_pkg::MAX_RANGE_RESET;
        end else if (cfg_we) begin
            unique case (rtrg_pkg::cfg_idx_t'(cfg_index))
                rtrg_pkg::CFG_ROW0:      row_reg[0]    <= cfg_wdata;
                rtrg_pkg::CFG_ROW1:      row_reg[1]    <= cfg_wdata;
                rtrg_pkg::CFG_ROW2:      row_reg[2]    <= cfg_wdata;
                rtrg_pkg::CFG_MAX_RANGE: max_range_reg <= cfg_wdata[RNG_W-1:0];
            endcase
        end
    end

    logic signed [COEF_W-1:0] coef  [3][3];
    logic signed [T_W-1:0]    trans [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = row_reg[r][ROW_W-1-c*COEF_W -: COEF_W];
            end
            trans[r] = row_reg[r][T_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the next one can take its word
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = m_ready | ~v5_reg;
    assign rdy4    = rdy5 | ~v4_reg;
    assign rdy3    = rdy4 | ~v3_reg;
    assign rdy2    = rdy3 | ~v2_reg;
    assign rdy1    = rdy2 | ~v1_reg;
    assign s_ready = rdy1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products. Index k = 0..2 position rows, 3..5 velocity rows
    // ------------------------------------------------------------------
    logic signed [CW-1:0]     vec_in [2][3];
    logic signed [PROD_W-1:0] prod_next [6][3];
    logic signed [PROD_W-1:0] prod_reg  [6][3];

    assign vec_in[0][0] = s_pos_x;
    assign vec_in[0][1] = s_pos_y;
    assign vec_in[0][2] = s_pos_z;
    assign vec_in[1][0] = s_vel_x;
    assign vec_in[1][1] = s_vel_y;
    assign vec_in[1][2] = s_vel_z;

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_next[g*3+r][c] = PROD_W'(coef[r][c]) * PROD_W'(vec_in[g][c]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row sums, translation and rounding offset
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_next [6];
    logic signed [ACC_W-1:0] acc_reg  [6];

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            for (int r = 0; r < 3; r++) begin
                acc_next[g*3+r] = ACC_W'(prod_reg[g*3+r][0]) + ACC_W'(prod_reg[g*3+r][1])
                                + ACC_W'(prod_reg[g*3+r][2]) + RND_HALF;
                if (g == 0) begin
                    acc_next[g*3+r] = acc_next[g*3+r] + (ACC_W'(trans[r]) <<< F);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            acc_reg <= acc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: floor shift, saturation, range pre-check on x' and y'
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0] rnd [6];
    logic signed [EXT_W-1:0] ext [6];
    logic                    fits [6];
    logic signed [CW-1:0]    sat_next [6];
    logic                    clip_next;
    logic [RND_W-ABS_W-1:0]  hi_x, hi_y;
    logic                    inr_next;
    logic [ABS_W-1:0]        abs_x_next, abs_y_next;

    logic signed [CW-1:0]    sat3_reg [6];
    logic                    clip3_reg;
    logic                    inr3_reg;
    logic [ABS_W-1:0]        abs_x3_reg, abs_y3_reg;

    always_comb begin
        clip_next = 1'b0;
        for (int k = 0; k < 6; k++) begin
            rnd[k]  = $signed(acc_reg[k][ACC_W-1:F]);
            ext[k]  = EXT_W'(rnd[k]);
            // value fits when all bits from the sign position up agree
            fits[k] = (&ext[k][EXT_W-1:CW-1]) | ~(|ext[k][EXT_W-1:CW-1]);
            sat_next[k] = fits[k] ? ext[k][CW-1:0]
                                  : {ext[k][EXT_W-1], {(CW-1){~ext[k][EXT_W-1]}}};
            clip_next = clip_next | ~fits[k];
        end
    end

    // |v| <= 65535: upper bits all zero, or all ones with a nonzero low part
    assign hi_x     = rnd[0][RND_W-1:ABS_W];
    assign hi_y     = rnd[1][RND_W-1:ABS_W];
    assign inr_next = (~(|hi_x) | (&hi_x & |rnd[0][ABS_W-1:0]))
                    & (~(|hi_y) | (&hi_y & |rnd[1][ABS_W-1:0]));
    assign abs_x_next = rnd[0][RND_W-1] ? ABS_W'(~rnd[0][ABS_W-1:0] + 1'b1)
                                        : rnd[0][ABS_W-1:0];
    assign abs_y_next = rnd[1][RND_W-1] ? ABS_W'(~rnd[1][ABS_W-1:0] + 1'b1)
                                        : rnd[1][ABS_W-1:0];

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sat3_reg   <= sat_next;
            clip3_reg  <= clip_next;
            inr3_reg   <= inr_next;
            abs_x3_reg <= abs_x_next;
            abs_y3_reg <= abs_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares
    // ------------------------------------------------------------------
    logic signed [CW-1:0] sat4_reg [6];
    logic                 clip4_reg;
    logic                 inr4_reg;
    logic [SQ_W-1:0]      sq_x4_reg, sq_y4_reg;
    logic [MSQ_W-1:0]     msq4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            sat4_reg  <= sat3_reg;
            clip4_reg <= clip3_reg;
            inr4_reg  <= inr3_reg;
            sq_x4_reg <= SQ_W'(abs_x3_reg) * SQ_W'(abs_x3_reg);
            sq_y4_reg <= SQ_W'(abs_y3_reg) * SQ_W'(abs_y3_reg);
            msq4_reg  <= MSQ_W'(max_range_reg) * MSQ_W'(max_range_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: range compare, output register
    // ------------------------------------------------------------------
    logic keep_next;

    assign keep_next = inr4_reg
                     & ((CMP_W'(sq_x4_reg) + CMP_W'(sq_y4_reg)) < CMP_W'(msq4_reg));

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            m_out_pos_x <= sat4_reg[0];
            m_out_pos_y <= sat4_reg[1];
            m_out_pos_z <= sat4_reg[2];
            m_out_vel_x <= sat4_reg[3];
            m_out_vel_y <= sat4_reg[4];
            m_out_vel_z <= sat4_reg[5];
            m_keep      <= keep_next;
            m_saturated <= clip4_reg;
        end
    end

endmodule

// ===== sv/rtrg_checker.sv =====
// ----------------------------------------------------------------------------
// rtrg_checker
// Port-level checks for the rigid transform / range gate block.
// ----------------------------------------------------------------------------
module rtrg_checker #(
    parameter int COORD_WIDTH = rtrg_pkg::COORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rtrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtrg_pkg::ROW_W-1:0]     cfg_wdata,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [COORD_WIDTH-1:0]  m_out_pos_x,
    input  logic signed [COORD_WIDTH-1:0]  m_out_pos_y,
    input  logic signed [COORD_WIDTH-1:0]  m_out_pos_z,
    input  logic signed [COORD_WIDTH-1:0]  m_out_vel_x,
    input  logic signed [COORD_WIDTH-1:0]  m_out_vel_y,
    input  logic signed [COORD_WIDTH-1:0]  m_out_vel_z,
    input  logic                           m_keep,
    input  logic                           m_saturated
);

    localparam int CW    = COORD_WIDTH;
    localparam int RNG_W = rtrg_pkg::RANGE_W;
    localparam int PSQ_W = 2 * CW;
    localparam int MSQ_W = 2 * RNG_W;
    localparam int CMP_W = ((PSQ_W > MSQ_W) ? PSQ_W : MSQ_W) + 1;

    // shadow of max_range as seen on the config port
    logic [RNG_W-1:0] max_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= rtrg_pkg::MAX_RANGE_RESET;
        end else if (cfg_we && cfg_index == rtrg_pkg::CFG_MAX_RANGE) begin
            max_range_reg <= cfg_wdata[RNG_W-1:0];
        end
    end

    logic signed [PSQ_W-1:0] x_sq, y_sq;
    logic [CMP_W-1:0]        dist_sq, lim_sq;

    assign x_sq    = PSQ_W'(m_out_pos_x) * PSQ_W'(m_out_pos_x);
    assign y_sq    = PSQ_W'(m_out_pos_y) * PSQ_W'(m_out_pos_y);
    assign dist_sq = CMP_W'(unsigned'(x_sq)) + CMP_W'(unsigned'(y_sq));
    assign lim_sq  = CMP_W'(MSQ_W'(max_range_reg) * MSQ_W'(max_range_reg));

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output word present right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_pos_x) && $stable(m_out_pos_y)
            && $stable(m_out_pos_z) && $stable(m_out_vel_x) && $stable(m_out_vel_y)
            && $stable(m_out_vel_z) && $stable(m_keep) && $stable(m_saturated))
        else $error("stalled output word changed");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no output word waits");

    a_keep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_keep && !m_saturated |-> dist_sq < lim_sq)
        else $error("keep set for a detection outside max_range");

endmodule

bind rigid_transform_range_gate_top rtrg_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_rtrg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_pos_x (m_out_pos_x),
    .m_out_pos_y (m_out_pos_y),
    .m_out_pos_z (m_out_pos_z),
    .m_out_vel_x (m_out_vel_x),
    .m_out_vel_y (m_out_vel_y),
    .m_out_vel_z (m_out_vel_z),
    .m_keep      (m_keep),
    .m_saturated (m_saturated)
);

// ===== verif/rigid_transform_range_gate_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_transform_range_gate_top_test
// Drives radar detections through the rigid transform / range gate block
// under random flow control and checks every output word against a local
// fixed-point model of the transform, the rounding, the clipping and the gate.
// ----------------------------------------------------------------------------
module rigid_transform_range_gate_top_test;

    localparam int     COORD_W    = rtrg_pkg::COORD_WIDTH_DEF;
    localparam int     FRAC_W     = rtrg_pkg::COEF_FRAC_DEF;
    localparam int     ROW_W      = rtrg_pkg::ROW_W;
    localparam int     RANGE_W    = rtrg_pkg::RANGE_W;
    localparam int     COEF_W     = rtrg_pkg::COEF_W;
    localparam int     T_W        = rtrg_pkg::T_W;
    localparam longint COORD_MAX  = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam longint GATE_BOUND = (longint'(1) <<< rtrg_pkg::ABS_W) - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_W - 1);
    localparam int     STALL_LIMIT = 3000;
    localparam int     DRAIN_CYCLES = 12;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t vel_x;
        coord_t vel_y;
        coord_t vel_z;
    } detection_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        coord_t vel_x;
        coord_t vel_y;
        coord_t vel_z;
        logic   keep;
        logic   saturated;
    } point_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    rtrg_pkg::cfg_idx_t cfg_index;
    logic [ROW_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    coord_t             s_pos_x, s_pos_y, s_pos_z;
    coord_t             s_vel_x, s_vel_y, s_vel_z;
    logic               m_valid;
    logic               m_ready;
    coord_t             m_out_pos_x, m_out_pos_y, m_out_pos_z;
    coord_t             m_out_vel_x, m_out_vel_y, m_out_vel_z;
    logic               m_keep;
    logic               m_saturated;

    rigid_transform_range_gate_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_vel_x     (s_vel_x),
        .s_vel_y     (s_vel_y),
        .s_vel_z     (s_vel_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pos_x (m_out_pos_x),
        .m_out_pos_y (m_out_pos_y),
        .m_out_pos_z (m_out_pos_z),
        .m_out_vel_x (m_out_vel_x),
        .m_out_vel_y (m_out_vel_y),
        .m_out_vel_z (m_out_vel_z),
        .m_keep      (m_keep),
        .m_saturated (m_saturated)
    );

    // Shadow copy of the calibration registers
    logic [ROW_W-1:0]   row_cfg [3];
    logic [RANGE_W-1:0] range_cfg;

    detection_t detections_pending [$];
    point_t     predicted_points [$];

    int   n_offered;
    int   n_taken;
    int   n_points;
    int   n_errors;
    int   idle_cycles;
    logic s_fire;
    logic m_fire;

    // Sender bursts and gaps
    detection_t tx_word;
    int         burst_left;
    int         gap_left;

    // Receiver stall pattern
    int rx_mode;
    int rx_mode_left;
    int rx_tick;
    int rx_hold_left;
    int rx_holds_done;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (v < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(v);
    endfunction

    function automatic point_t transform_detection(detection_t d);
        longint                     src_p [3];
        longint                     src_v [3];
        longint                     acc;
        longint                     res_p [3];
        longint                     res_v [3];
        longint                     dist2;
        longint                     limit2;
        coord_t                     sat_p [3];
        coord_t                     sat_v [3];
        logic signed [COEF_W-1:0]   coef [3];
        logic signed [T_W-1:0]      offset;
        logic                       clip;
        logic                       in_gate;
        src_p[0] = d.pos_x;
        src_p[1] = d.pos_y;
        src_p[2] = d.pos_z;
        src_v[0] = d.vel_x;
        src_v[1] = d.vel_y;
        src_v[2] = d.vel_z;
        clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            coef[0] = row_cfg[r][63:48];
            coef[1] = row_cfg[r][47:32];
            coef[2] = row_cfg[r][31:16];
            offset  = row_cfg[r][15:0];
            acc = longint'(coef[0]) * src_p[0] + longint'(coef[1]) * src_p[1]
                + longint'(coef[2]) * src_p[2] + (longint'(offset) <<< FRAC_W);
            res_p[r] = (acc + ROUND_HALF) >>> FRAC_W;
            acc = longint'(coef[0]) * src_v[0] + longint'(coef[1]) * src_v[1]
                + longint'(coef[2]) * src_v[2];
            res_v[r] = (acc + ROUND_HALF) >>> FRAC_W;
            sat_p[r] = clamp_coord(res_p[r]);
            sat_v[r] = clamp_coord(res_v[r]);
            if (longint'(sat_p[r]) != res_p[r] || longint'(sat_v[r]) != res_v[r])
                clip = 1'b1;
        end
        // gate uses unclipped x', y'; beyond the bound no range can admit them
        in_gate = 1'b0;
        if (res_p[0] <= GATE_BOUND && res_p[0] >= -GATE_BOUND &&
            res_p[1] <= GATE_BOUND && res_p[1] >= -GATE_BOUND) begin
            dist2   = res_p[0] * res_p[0] + res_p[1] * res_p[1];
            limit2  = longint'(range_cfg) * longint'(range_cfg);
            in_gate = (dist2 < limit2);
        end
        return {sat_p[0], sat_p[1], sat_p[2], sat_v[0], sat_v[1], sat_v[2], in_gate, clip};
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= 40)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $realtime, name, want, got);
        end
    endtask

    // Monitor: accepts on both channels, sampled at the rising edge
    always @(posedge aclk) begin
        point_t want;
        point_t pred;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_fire) begin
            pred = transform_detection(
                {s_pos_x, s_pos_y, s_pos_z, s_vel_x, s_vel_y, s_vel_z});
            predicted_points = {predicted_points, pred};
            n_taken++;
        end
        if (m_fire) begin
            n_points++;
            if (predicted_points.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t ns: output word with none expected, expected none, actual %h",
                             $realtime, {m_out_pos_x, m_out_pos_y, m_out_pos_z,
                                         m_out_vel_x, m_out_vel_y, m_out_vel_z,
                                         m_keep, m_saturated});
            end else begin
                want = predicted_points.pop_front();
                check_field("out_pos_x", want.pos_x, m_out_pos_x);
                check_field("out_pos_y", want.pos_y, m_out_pos_y);
                check_field("out_pos_z", want.pos_z, m_out_pos_z);
                check_field("out_vel_x", want.vel_x, m_out_vel_x);
                check_field("out_vel_y", want.vel_y, m_out_vel_y);
                check_field("out_vel_z", want.vel_z, m_out_vel_z);
                check_field("keep", want.keep, m_keep);
                check_field("saturated", want.saturated, m_saturated);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("rigid_transform_range_gate_top regression: fail");
            $finish;
        end
    end

    // Sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // word still waiting, hold it
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (detections_pending.size() > 0) begin
            tx_word  = detections_pending.pop_front();
            s_pos_x <= tx_word.pos_x;
            s_pos_y <= tx_word.pos_y;
            s_pos_z <= tx_word.pos_z;
            s_vel_x <= tx_word.vel_x;
            s_vel_y <= tx_word.vel_y;
            s_vel_z <= tx_word.vel_z;
            s_valid <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver, with two long hold-offs so the pipeline backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_hold_left == 0 && rx_holds_done < 2 &&
                n_points >= (rx_holds_done == 0 ? 300 : 1000)) begin
                rx_hold_left = 120;
                rx_holds_done++;
            end
            rx_tick++;
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(32, 256);
                end else begin
                    rx_mode_left--;
                end
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(0, 1);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    task automatic write_reg(rtrg_pkg::cfg_idx_t idx, logic [ROW_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == rtrg_pkg::CFG_MAX_RANGE)
            range_cfg = data[RANGE_W-1:0];
        else
            row_cfg[idx] = data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_detection(int px, int py, int pz, int vx, int vy, int vz);
        detection_t d;
        d = {coord_t'(px), coord_t'(py), coord_t'(pz),
             coord_t'(vx), coord_t'(vy), coord_t'(vz)};
        detections_pending = {detections_pending, d};
        n_offered++;
    endtask

    task automatic drain_pipeline();
        while (n_taken != n_offered || predicted_points.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(int reach);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return coord_t'($urandom);
            4, 5: return coord_t'(int'($urandom_range(0, 4095)) - 2048);
            6: begin
                case ($urandom_range(0, 4))
                    0: return coord_t'(COORD_MAX);
                    1: return coord_t'(COORD_MIN);
                    2: return '0;
                    3: return '1;
                    default: return coord_t'(1);
                endcase
            end
            default: return coord_t'(int'($urandom_range(0, 2 * reach)) - reach);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_row(int r, int style, int perm, int flip);
        logic [COEF_W-1:0] coef [3];
        logic [T_W-1:0]    offset;
        logic [COEF_W-1:0] corner [6];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hC000, 16'h4000, 16'hFFFF};
        case (style)
            0: return {$urandom, $urandom};
            1: begin
                // near identity with a small misalignment
                for (int c = 0; c < 3; c++)
                    coef[c] = COEF_W'(int'($urandom_range(0, 1024)) - 512);
                coef[r] = coef[r] + 16'h4000;
                offset  = T_W'(int'($urandom_range(0, 4096)) - 2048);
            end
            2: begin
                // axis permutation with sign flips
                for (int c = 0; c < 3; c++)
                    coef[c] = '0;
                coef[(r + perm) % 3] = flip[r] ? 16'hC000 : 16'h4000;
                offset = T_W'($urandom);
            end
            default: begin
                for (int c = 0; c < 3; c++)
                    coef[c] = corner[$urandom_range(0, 5)];
                offset = corner[$urandom_range(0, 2)];
            end
        endcase
        return {coef[0], coef[1], coef[2], offset};
    endfunction

    initial begin : stimulus
        logic [ROW_W-1:0]   wdata;
        logic [RANGE_W-1:0] range_pick;
        int                 style;
        int                 perm;
        int                 flip;
        int                 reach;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = rtrg_pkg::CFG_ROW0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_pos_x      = '0;
        s_pos_y      = '0;
        s_pos_z      = '0;
        s_vel_x      = '0;
        s_vel_y      = '0;
        s_vel_z      = '0;
        m_ready      = 1'b0;
        s_fire       = 1'b0;
        m_fire       = 1'b0;
        n_offered    = 0;
        n_taken      = 0;
        n_points     = 0;
        n_errors     = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        gap_left     = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
        rx_tick      = 0;
        rx_hold_left = 0;
        rx_holds_done = 0;
        row_cfg[0]   = rtrg_pkg::ROW0_RESET;
        row_cfg[1]   = rtrg_pkg::ROW1_RESET;
        row_cfg[2]   = rtrg_pkg::ROW2_RESET;
        range_cfg    = rtrg_pkg::MAX_RANGE_RESET;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset transform: field extremes and the range boundary
        queue_detection(0, 0, 0, 0, 0, 0);
        queue_detection(32767, 32767, 32767, 32767, 32767, 32767);
        queue_detection(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_detection(6400, 0, 5, -7, 9, -11);
        queue_detection(6399, 0, -1, 1, -1, 1);
        queue_detection(0, -6400, 0, 0, 0, 0);
        queue_detection(4525, 4525, 100, 0, 0, 0);
        queue_detection(-4526, 4526, -100, 0, 0, 0);
        drain_pipeline();

        // Half-unit products: rounding ties on both signs
        write_reg(rtrg_pkg::CFG_ROW0, 64'h2000_E000_0001_0000);
        write_reg(rtrg_pkg::CFG_ROW1, 64'hE000_2000_FFFF_0000);
        write_reg(rtrg_pkg::CFG_ROW2, 64'h0001_FFFF_2000_0000);
        write_reg(rtrg_pkg::CFG_MAX_RANGE, {$urandom, 16'h0000, 16'hFFFF});
        queue_detection(1, 0, 0, 1, 0, 0);
        queue_detection(-1, 0, 0, -1, 0, 0);
        queue_detection(0, 1, 0, 0, -1, 0);
        queue_detection(3, -3, 1, -3, 3, -1);
        queue_detection(32767, -32768, 32767, -32768, 32767, -32768);
        drain_pipeline();

        // Full-scale gains: clipping on every field, closed gate
        write_reg(rtrg_pkg::CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(rtrg_pkg::CFG_ROW1, 64'h8000_8000_8000_8000);
        write_reg(rtrg_pkg::CFG_ROW2, 64'h8000_7FFF_0000_8000);
        write_reg(rtrg_pkg::CFG_MAX_RANGE, 64'h0);
        queue_detection(32767, 32767, 32767, 32767, 32767, 32767);
        queue_detection(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_detection(32767, -32768, 0, -32768, 32767, 0);
        queue_detection(1, 1, 1, -1, -1, -1);
        queue_detection(0, 0, 0, 0, 0, 0);
        drain_pipeline();

        // Widest gate against x' just inside and past the magnitude bound
        write_reg(rtrg_pkg::CFG_ROW0, 64'h7FFF_7FFF_0000_7FFF);
        write_reg(rtrg_pkg::CFG_ROW1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(rtrg_pkg::CFG_ROW2, 64'h0);
        write_reg(rtrg_pkg::CFG_MAX_RANGE, 64'hFFFF);
        queue_detection(16384, 0, 0, 16384, 0, 0);
        queue_detection(16385, 0, 0, 0, 16385, 0);
        queue_detection(32767, 32767, 0, 32767, 32767, 32767);
        queue_detection(-32768, -32768, 0, -32768, -32768, -32768);
        drain_pipeline();

        // Random calibrations, each followed by a random detection stream
        for (int phase = 0; phase < 8; phase++) begin
            style = $urandom_range(0, 3);
            perm  = $urandom_range(0, 2);
            flip  = $urandom_range(0, 7);
            for (int r = 0; r < 3; r++)
                write_reg(rtrg_pkg::cfg_idx_t'(r), random_row(r, style, perm, flip));
            case ($urandom_range(0, 3))
                0: range_pick = '0;
                1: range_pick = '1;
                2: range_pick = RANGE_W'($urandom_range(1, 12000));
                default: range_pick = RANGE_W'($urandom);
            endcase
            wdata = {$urandom, $urandom};
            wdata[RANGE_W-1:0] = range_pick;
            write_reg(rtrg_pkg::CFG_MAX_RANGE, wdata);
            reach = (int'(range_pick) * 3) / 2;
            if (reach > 32767)
                reach = 32767;
            if (reach < 64)
                reach = 64;
            repeat (190)
                queue_detection(pick_coord(reach), pick_coord(reach), pick_coord(reach),
                                pick_coord(reach), pick_coord(reach), pick_coord(reach));
            drain_pipeline();
        end

        if (n_errors == 0)
            $display("rigid_transform_range_gate_top regression: pass");
        else
            $display("rigid_transform_range_gate_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rtrg_pkg.sv
sv/rigid_transform_range_gate_top.sv
sv/rtrg_checker.sv
verif/rigid_transform_range_gate_top_test.sv
